[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms, reset masks the check
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

[src/wtsp_pkg.sv]
// ----------------------------------------------------------------------------
// wtsp_pkg
// widths, register codes and shared helpers of the projection pipeline
// ----------------------------------------------------------------------------
package wtsp_pkg;

  localparam int CoordW = 32;
  localparam int RegW   = 64;
  localparam int ProdW  = 64;
  localparam int SumW   = 66;
  localparam int ClipW  = 52;
  localparam int HalfW  = 14;
  localparam int NumW   = 66;
  localparam int FracW  = 17;
  localparam int IntW   = 21;
  localparam int QuoW   = IntW + FracW;
  localparam int ValW   = 40;
  localparam int CfgIdxW = 4;
  localparam int NumMat = 6;

  // smallest q16.16 value not below 0.1
  localparam logic signed [ClipW-1:0] DepthMinQ16 = ClipW'(64'sd6554);
  localparam logic signed [ClipW-1:0] SatMax = ClipW'(64'sd2147483647);
  localparam logic signed [ClipW-1:0] SatMin = ClipW'(-64'sd2147483648);
  localparam logic signed [CoordW-1:0] CoordMax = 32'sh7fff_ffff;
  localparam logic signed [CoordW-1:0] CoordMin = 32'sh8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROW0_C01 = 4'd0,
    REG_ROW0_C23 = 4'd1,
    REG_ROW1_C01 = 4'd2,
    REG_ROW1_C23 = 4'd3,
    REG_ROW3_C01 = 4'd4,
    REG_ROW3_C23 = 4'd5,
    REG_HALF_W   = 4'd6,
    REG_HALF_H   = 4'd7
  } cfg_reg_e;

  // one axis division request
  typedef struct packed {
    logic signed [NumW-1:0]  num;
    logic signed [ClipW-1:0] den;
    logic [HalfW-1:0]        half;
    logic                    flip;
  } div_req_t;

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [ClipW-1:0] v);
    logic signed [CoordW-1:0] r;
    if (v > SatMax) begin
      r = CoordMax;
    end else if (v < SatMin) begin
      r = CoordMin;
    end else begin
      r = CoordW'(v);
    end
    return r;
  endfunction

endpackage

[src/wtsp_div.sv]
// ----------------------------------------------------------------------------
// wtsp_div
// pipelined restoring divider for one axis, one quotient bit per stage,
// followed by rounding, viewport offset and saturation
// ----------------------------------------------------------------------------
module wtsp_div (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  wtsp_pkg::div_req_t              req_i,
  output logic signed [wtsp_pkg::CoordW-1:0] coord_o
);
  import wtsp_pkg::*;

  typedef struct packed {
    logic [ClipW-1:0] rem;
    logic [QuoW-1:0]  low;
    logic [QuoW-1:0]  quo;
    logic [ClipW-1:0] dm;
    logic [HalfW-1:0] half;
    logic             neg;
    logic             ovf;
  } step_t;

  logic [NumW-1:0]  nm_q;
  logic [ClipW-1:0] dm_q;
  logic [HalfW-1:0] half_q;
  logic             neg_q;
  step_t            step_q [QuoW+1];
  logic [ClipW+IntW-1:0] lim;
  logic [QuoW-1:0]  mag;
  logic signed [ValW-1:0] val;
  logic signed [CoordW-1:0] coord_d, coord_q;

  // magnitudes and result sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nm_q   <= req_i.num[NumW-1] ? NumW'(-req_i.num) : NumW'(req_i.num);
      dm_q   <= req_i.den[ClipW-1] ? ClipW'(-req_i.den) : ClipW'(req_i.den);
      half_q <= req_i.half;
      neg_q  <= req_i.flip ^ req_i.num[NumW-1] ^ req_i.den[ClipW-1];
    end
  end

  // integer part above 2^20 saturates whatever the fraction
  assign lim = ({{IntW{1'b0}}, dm_q} << (IntW - 1)) + {{IntW{1'b0}}, dm_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_q[0].rem  <= ClipW'(nm_q >> IntW);
      step_q[0].low  <= {nm_q[IntW-1:0], {FracW{1'b0}}};
      step_q[0].quo  <= '0;
      step_q[0].dm   <= dm_q;
      step_q[0].half <= half_q;
      step_q[0].neg  <= neg_q;
      step_q[0].ovf  <= {{(ClipW+IntW-NumW){1'b0}}, nm_q} >= lim;
    end
  end

  for (genvar i = 0; i < QuoW; i++) begin : g_step
    logic [ClipW:0] trial;
    logic [ClipW:0] diff;
    logic           ge;
    step_t          nxt;

    always_comb begin
      trial = {step_q[i].rem, step_q[i].low[QuoW-1]};
      diff  = trial - {1'b0, step_q[i].dm};
      ge    = trial >= {1'b0, step_q[i].dm};
      nxt   = step_q[i];
      nxt.rem = ge ? diff[ClipW-1:0] : trial[ClipW-1:0];
      nxt.low = {step_q[i].low[QuoW-2:0], 1'b0};
      nxt.quo = {step_q[i].quo[QuoW-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        step_q[i+1] <= nxt;
      end
    end
  end

  // round half away from zero, then offset by half viewport
  always_comb begin
    mag = QuoW'(({1'b0, step_q[QuoW].quo} + {{QuoW{1'b0}}, 1'b1}) >> 1);
    val = step_q[QuoW].neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    val = val + $signed(ValW'({step_q[QuoW].half, 16'h0000}));
    if (step_q[QuoW].ovf) begin
      coord_d = step_q[QuoW].neg ? CoordMin : CoordMax;
    end else begin
      coord_d = sat32(ClipW'(val));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      coord_q <= coord_d;
    end
  end

  assign coord_o = coord_q;

endmodule

[src/world_to_screen_projection.sv]
// ----------------------------------------------------------------------------
// world_to_screen_projection
// projects a q16.16 world point through a preloaded matrix to pixel space
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | word
//  in      | input     | in_valid_i / in_stall_o  | world_x, world_y, world_z
//  out     | output    | out_valid_o / out_stall_i| screen_x, screen_y, depth, flags
//  cfg     | input     | cfg_valid_i / cfg_ready_o| register index, 64-bit data
//
//  one point per clock sustained while no output stall holds the pipeline;
//  45 register stages lie between the accepting edge and the result word;
//  most of them are the 38 quotient-bit stages of the two axis dividers
//  all stages advance together; a stall on a valid output holds the whole pipeline
//  reset clears valid bits and configuration registers, nothing else
// ----------------------------------------------------------------------------
module world_to_screen_projection (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [wtsp_pkg::CoordW-1:0]  world_x_i,
  input  logic signed [wtsp_pkg::CoordW-1:0]  world_y_i,
  input  logic signed [wtsp_pkg::CoordW-1:0]  world_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [wtsp_pkg::CoordW-1:0]  screen_x_o,
  output logic signed [wtsp_pkg::CoordW-1:0]  screen_y_o,
  output logic signed [wtsp_pkg::CoordW-1:0]  depth_o,
  output logic                                on_screen_o,
  output logic                                depth_zero_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wtsp_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [wtsp_pkg::RegW-1:0]           cfg_data_i
);
  import wtsp_pkg::*;
  `include "assert_macros.svh"

  localparam int FrontLat = 4;
  localparam int DivLat   = QuoW + 3;
  localparam int NumStg   = FrontLat + DivLat;

  typedef struct packed {
    logic signed [CoordW-1:0] depth;
    logic                     on;
    logic                     zero;
  } flags_t;

  logic [RegW-1:0]  mat_q [NumMat];
  logic [HalfW-1:0] half_w_q, half_h_q;
  logic [NumStg-1:0] vld_q;
  logic             en;

  logic signed [ProdW-1:0]  prod_q [3][3];
  logic signed [SumW-1:0]   sum_q [3];
  logic signed [ClipW-1:0]  clip_q [3];
  logic signed [NumW-1:0]   num_q [2];
  logic signed [ClipW-1:0]  w_q;
  flags_t                   flag_q [DivLat+1];
  div_req_t                 req_x, req_y;
  logic signed [CoordW-1:0] div_x, div_y;
  logic signed [CoordW-1:0] xyz [3];

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumMat; i++) begin
        mat_q[i] <= '0;
      end
      half_w_q <= '0;
      half_h_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ROW0_C01: mat_q[0] <= cfg_data_i;
        REG_ROW0_C23: mat_q[1] <= cfg_data_i;
        REG_ROW1_C01: mat_q[2] <= cfg_data_i;
        REG_ROW1_C23: mat_q[3] <= cfg_data_i;
        REG_ROW3_C01: mat_q[4] <= cfg_data_i;
        REG_ROW3_C23: mat_q[5] <= cfg_data_i;
        REG_HALF_W:   half_w_q <= cfg_data_i[HalfW-1:0];
        REG_HALF_H:   half_h_q <= cfg_data_i[HalfW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  assign en         = !(vld_q[NumStg-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStg-2:0], in_valid_i};
    end
  end

  assign xyz[0] = world_x_i;
  assign xyz[1] = world_y_i;
  assign xyz[2] = world_z_i;

  // dot products for rows 0, 1 and 3
  for (genvar r = 0; r < 3; r++) begin : g_row
    logic signed [SumW-1:0] rnd;

    for (genvar c = 0; c < 3; c++) begin : g_col
      logic signed [CoordW-1:0] coef;
      assign coef = $signed(mat_q[2*r + c/2][CoordW*(c%2) +: CoordW]);

      always_ff @(posedge clk_i) begin
        if (en) begin
          prod_q[r][c] <= ProdW'(coef) * ProdW'(xyz[c]);
        end
      end
    end

    // round to q16.16 with ties up, then add the w term
    assign rnd = (sum_q[r] + SumW'(32'sd32768)) >>> 16;

    always_ff @(posedge clk_i) begin
      if (en) begin
        sum_q[r]  <= SumW'(prod_q[r][0]) + SumW'(prod_q[r][1]) + SumW'(prod_q[r][2]);
        clip_q[r] <= ClipW'(rnd) + ClipW'($signed(mat_q[2*r+1][RegW-1 -: CoordW]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q[0] <= NumW'(clip_q[0]) * $signed({{(NumW-HalfW){1'b0}}, half_w_q});
      num_q[1] <= NumW'(clip_q[1]) * $signed({{(NumW-HalfW){1'b0}}, half_h_q});
      w_q      <= clip_q[2];
      flag_q[0].depth <= sat32(clip_q[2]);
      flag_q[0].on    <= clip_q[2] >= DepthMinQ16;
      flag_q[0].zero  <= clip_q[2] == '0;
      for (int i = 0; i < DivLat; i++) begin
        flag_q[i+1] <= flag_q[i];
      end
    end
  end

  // y axis is mirrored
  always_comb begin
    req_x.num  = num_q[0];
    req_x.den  = w_q;
    req_x.half = half_w_q;
    req_x.flip = 1'b0;
    req_y.num  = num_q[1];
    req_y.den  = w_q;
    req_y.half = half_h_q;
    req_y.flip = 1'b1;
  end

  wtsp_div u_div_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .req_i   (req_x),
    .coord_o (div_x)
  );

  wtsp_div u_div_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .req_i   (req_y),
    .coord_o (div_y)
  );

  assign out_valid_o  = vld_q[NumStg-1];
  assign depth_zero_o = flag_q[DivLat].zero;
  assign on_screen_o  = flag_q[DivLat].on;
  assign depth_o      = flag_q[DivLat].depth;
  assign screen_x_o   = flag_q[DivLat].zero ? '0 : div_x;
  assign screen_y_o   = flag_q[DivLat].zero ? '0 : div_y;

  `ASSERT_CLK(a_accept_enters, (in_valid_i && !in_stall_o) |=> vld_q[0])
  `ASSERT_NEVER(a_zero_not_on, out_valid_o && depth_zero_o && on_screen_o)
  `ASSERT_NEVER(a_neg_depth_on, out_valid_o && depth_o[CoordW-1] && on_screen_o)
  `ASSERT_CLK(a_zero_depth_out, (out_valid_o && depth_zero_o) |-> (depth_o == '0))

endmodule
